// ===== rtl/ttt_pkg.sv =====
// Shared types and constants for the transaction tracker.
// Used by every module in the rtl folder; depends on nothing else.
`default_nettype none
package ttt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TIME_W      = 32;
    localparam int ID_W        = 16;

    localparam logic [TIME_W-1:0] LIFETIME_RESET = TIME_W'(1000000);

    typedef enum logic [1:0] {
        ACT_CREATE = 2'd0,
        ACT_ACCEPT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NO_ACCEPT = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_EVAL    = 2'd1,
        ST_COMPACT = 2'd2,
        ST_DONE    = 2'd3
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD     = 3'd0,
        CELL_MARK_AGE = 3'd1,
        CELL_MARK_ID  = 3'd2,
        CELL_ACCEPT   = 3'd3,
        CELL_CLEAR    = 3'd4,
        CELL_COMPACT  = 3'd5,
        CELL_INSERT   = 3'd6
    } cell_op_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] offer;
        logic [TIME_W-1:0] astamp;
        logic              seen;
    } entry_data_t;

    typedef struct packed {
        logic        valid;
        logic        kill;
        entry_data_t data;
    } entry_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] lifetime;
    } cell_cmd_t;

    typedef struct packed {
        logic              any_kill;
        logic              any_sel;
        logic              sel_seen;
        logic [TIME_W-1:0] sel_astamp;
        logic              head_valid;
        logic [ID_W-1:0]   head_id;
        logic              tail_valid;
    } chain_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ttt_cell.sv =====
// One table position: holds one entry and its drop mark.
// Depends on ttt_pkg; instantiated in a row by ttt_chain.
`default_nettype none
module ttt_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ttt_pkg::cell_cmd_t cmd,
    input  wire ttt_pkg::entry_t    prev_entry,
    input  wire ttt_pkg::entry_t    next_entry,
    input  wire logic               found_in,
    input  wire logic               hole_in,
    output ttt_pkg::entry_t         entry,
    output logic                    sel,
    output logic                    found_out,
    output logic                    hole_out
);

    logic                        valid_reg;
    logic                        valid_next;
    logic                        kill_reg;
    logic                        kill_next;
    ttt_pkg::entry_data_t        data_reg;
    ttt_pkg::entry_data_t        data_next;
    logic                        match;
    logic [ttt_pkg::TIME_W-1:0]  age;

    assign match     = valid_reg && (data_reg.id == cmd.id) && (cmd.id != '0);
    assign sel       = match && !found_in;
    assign found_out = found_in || match;
    assign hole_out  = hole_in || (valid_reg && kill_reg);
    assign age       = cmd.now - data_reg.offer;

    assign entry.valid = valid_reg;
    assign entry.kill  = kill_reg;
    assign entry.data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        kill_next  = kill_reg;
        data_next  = data_reg;
        unique case (cmd.op)
            ttt_pkg::CELL_HOLD:
            begin
            end
            ttt_pkg::CELL_MARK_AGE:
            begin
                kill_next = valid_reg && (age > cmd.lifetime);
            end
            ttt_pkg::CELL_MARK_ID:
            begin
                kill_next = sel;
            end
            ttt_pkg::CELL_ACCEPT:
            begin
                if (sel)
                begin
                    data_next.astamp = cmd.now;
                    data_next.seen   = 1'b1;
                end
            end
            ttt_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
                kill_next  = 1'b0;
            end
            ttt_pkg::CELL_COMPACT:
            begin
                if (hole_out)
                begin
                    valid_next = next_entry.valid;
                    kill_next  = next_entry.kill;
                    data_next  = next_entry.data;
                end
            end
            ttt_pkg::CELL_INSERT:
            begin
                valid_next = prev_entry.valid;
                kill_next  = prev_entry.kill;
                data_next  = prev_entry.data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            kill_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            kill_reg  <= kill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/ttt_chain.sv =====
// Row of table cells linked to their neighbours, with the summary flags.
// Depends on ttt_pkg and ttt_cell.
`default_nettype none
module ttt_chain (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ttt_pkg::cell_cmd_t cmd,
    output ttt_pkg::chain_stat_t    stat
);

    localparam int N = ttt_pkg::TABLE_DEPTH;

    ttt_pkg::entry_t cell_q [N];
    ttt_pkg::entry_t ins_entry;
    ttt_pkg::entry_t empty_entry;
    logic [N:0]      found;
    logic [N:0]      hole;
    logic [N-1:0]    sel;

    assign ins_entry.valid       = 1'b1;
    assign ins_entry.kill        = 1'b0;
    assign ins_entry.data.id     = cmd.id;
    assign ins_entry.data.offer  = cmd.now;
    assign ins_entry.data.astamp = '0;
    assign ins_entry.data.seen   = 1'b0;

    assign empty_entry = '0;

    assign found[0] = 1'b0;
    assign hole[0]  = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        ttt_pkg::entry_t prev_e;
        ttt_pkg::entry_t next_e;

        if (i == 0)
        begin : g_first
            assign prev_e = ins_entry;
        end
        else
        begin : g_mid_prev
            assign prev_e = cell_q[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign next_e = empty_entry;
        end
        else
        begin : g_mid_next
            assign next_e = cell_q[i+1];
        end

        ttt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .found_in   (found[i]),
            .hole_in    (hole[i]),
            .entry      (cell_q[i]),
            .sel        (sel[i]),
            .found_out  (found[i+1]),
            .hole_out   (hole[i+1])
        );
    end

    always_comb
    begin
        logic                       seen_acc;
        logic [ttt_pkg::TIME_W-1:0] stamp_acc;
        seen_acc  = 1'b0;
        stamp_acc = '0;
        for (int k = 0; k < N; k++)
        begin
            seen_acc  = seen_acc | (sel[k] & cell_q[k].data.seen);
            stamp_acc = stamp_acc | ({ttt_pkg::TIME_W{sel[k]}} & cell_q[k].data.astamp);
        end
        stat.any_kill   = hole[N];
        stat.any_sel    = found[N];
        stat.sel_seen   = seen_acc;
        stat.sel_astamp = stamp_acc;
        stat.head_valid = cell_q[0].valid;
        stat.head_id    = cell_q[0].data.id;
        stat.tail_valid = cell_q[N-1].valid;
    end

endmodule
`default_nettype wire

// ===== rtl/ttt_ctrl.sv =====
// Sequencer for the tracker: takes a transaction, steps the cell row and
// holds the result in an output register. Depends on ttt_pkg.
`default_nettype none
module ttt_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire ttt_pkg::action_t              in_action,
    input  wire logic [ttt_pkg::ID_W-1:0]      in_tid,
    input  wire logic [ttt_pkg::TIME_W-1:0]    in_now,
    input  wire logic [ttt_pkg::TIME_W-1:0]    lifetime,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output ttt_pkg::status_t                   out_status,
    output logic [ttt_pkg::ID_W-1:0]           out_new_id,
    output logic [ttt_pkg::TIME_W-1:0]         out_accept_time,
    output ttt_pkg::cell_cmd_t                 cmd,
    input  wire ttt_pkg::chain_stat_t          stat
);

    ttt_pkg::state_t             state_reg;
    ttt_pkg::state_t             state_next;
    ttt_pkg::action_t            action_reg;
    logic [ttt_pkg::ID_W-1:0]    tid_reg;
    logic [ttt_pkg::TIME_W-1:0]  now_reg;
    ttt_pkg::status_t            res_status_reg;
    ttt_pkg::status_t            res_status_next;
    logic [ttt_pkg::ID_W-1:0]    res_new_id_reg;
    logic [ttt_pkg::ID_W-1:0]    res_new_id_next;
    logic [ttt_pkg::TIME_W-1:0]  res_atime_reg;
    logic [ttt_pkg::TIME_W-1:0]  res_atime_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    ttt_pkg::status_t            out_status_reg;
    logic [ttt_pkg::ID_W-1:0]    out_new_id_reg;
    logic [ttt_pkg::TIME_W-1:0]  out_atime_reg;
    logic                        out_load;
    logic [ttt_pkg::ID_W-1:0]    id_inc;
    logic [ttt_pkg::ID_W-1:0]    insert_id;

    assign id_inc    = stat.head_id + ttt_pkg::ID_W'(1);
    assign insert_id = (stat.head_valid && (id_inc != '0)) ? id_inc : ttt_pkg::ID_W'(1);
    assign out_load  = (state_reg == ttt_pkg::ST_DONE) && (!out_valid_reg || m_tready);

    assign m_tvalid        = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_new_id      = out_new_id_reg;
    assign out_accept_time = out_atime_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ttt_pkg::ST_EVAL;
                end
            end
            ttt_pkg::ST_EVAL:
            begin
                if (action_reg == ttt_pkg::ACT_CREATE || action_reg == ttt_pkg::ACT_REMOVE)
                begin
                    state_next = ttt_pkg::ST_COMPACT;
                end
                else
                begin
                    state_next = ttt_pkg::ST_DONE;
                end
            end
            ttt_pkg::ST_COMPACT:
            begin
                if (!stat.any_kill)
                begin
                    state_next = ttt_pkg::ST_DONE;
                end
            end
            ttt_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ttt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready        = (state_reg == ttt_pkg::ST_IDLE);
        cmd.op          = ttt_pkg::CELL_HOLD;
        cmd.id          = tid_reg;
        cmd.now         = now_reg;
        cmd.lifetime    = lifetime;
        res_status_next = res_status_reg;
        res_new_id_next = res_new_id_reg;
        res_atime_next  = res_atime_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        unique case (state_reg)
            ttt_pkg::ST_IDLE:
            begin
            end
            ttt_pkg::ST_EVAL:
            begin
                res_status_next = ttt_pkg::STAT_DONE;
                res_new_id_next = '0;
                res_atime_next  = '0;
                unique case (action_reg)
                    ttt_pkg::ACT_CREATE:
                    begin
                        cmd.op = ttt_pkg::CELL_MARK_AGE;
                    end
                    ttt_pkg::ACT_ACCEPT:
                    begin
                        cmd.op = ttt_pkg::CELL_ACCEPT;
                        if (!stat.any_sel)
                        begin
                            res_status_next = ttt_pkg::STAT_NOT_FOUND;
                        end
                    end
                    ttt_pkg::ACT_REMOVE:
                    begin
                        cmd.op = ttt_pkg::CELL_MARK_ID;
                        if (!stat.any_sel)
                        begin
                            res_status_next = ttt_pkg::STAT_NOT_FOUND;
                        end
                        else if (stat.sel_seen)
                        begin
                            res_atime_next = stat.sel_astamp;
                        end
                        else
                        begin
                            res_status_next = ttt_pkg::STAT_NO_ACCEPT;
                        end
                    end
                    ttt_pkg::ACT_CLEAR:
                    begin
                        cmd.op = ttt_pkg::CELL_CLEAR;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ttt_pkg::ST_COMPACT:
            begin
                if (stat.any_kill)
                begin
                    cmd.op = ttt_pkg::CELL_COMPACT;
                end
                else if (action_reg == ttt_pkg::ACT_CREATE)
                begin
                    if (stat.tail_valid)
                    begin
                        res_status_next = ttt_pkg::STAT_FULL;
                    end
                    else
                    begin
                        cmd.op          = ttt_pkg::CELL_INSERT;
                        cmd.id          = insert_id;
                        res_new_id_next = insert_id;
                    end
                end
            end
            ttt_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            action_reg <= in_action;
            tid_reg    <= in_tid;
            now_reg    <= in_now;
        end
        res_status_reg <= res_status_next;
        res_new_id_reg <= res_new_id_next;
        res_atime_reg  <= res_atime_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_new_id_reg <= res_new_id_reg;
            out_atime_reg  <= res_atime_reg;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ttt_pkg::ST_EVAL))
        else $error("accepted transaction did not start evaluation");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == ttt_pkg::ST_IDLE))
        else $error("result was not moved to the output register");

    a_full_only_on_create: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttt_pkg::ST_DONE && res_status_reg == ttt_pkg::STAT_FULL)
        |-> (action_reg == ttt_pkg::ACT_CREATE))
        else $error("table full reported for an action other than create");

    a_new_id_only_on_create: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttt_pkg::ST_DONE && action_reg != ttt_pkg::ACT_CREATE)
        |-> (res_new_id_reg == '0))
        else $error("new ID given by an action other than create");
`endif

endmodule
`default_nettype wire

// ===== rtl/transaction_tracker_with_timeout.sv =====
// Sequence: an accepted transaction passes through evaluation, then compaction for
// create and remove (repeated while entries marked for dropping remain), then done.
// Throughput: one transaction at a time; the next is taken in the cycle after the
// previous result is placed in the output register, paced by the cell row.
// Reset (rst_n, asynchronous, active low) empties the table and sets the
// lifetime register to 1000000 ticks. Depends on ttt_pkg, ttt_ctrl, ttt_chain.
`default_nettype none
module transaction_tracker_with_timeout (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,     // txn_id [15:0], now [47:16]
    input  wire logic [1:0]  s_tuser,     // action [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,     // new_id [15:0], accept_time [47:16]
    output logic [1:0]       m_tuser,     // status [1:0]
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);

    logic [ttt_pkg::TIME_W-1:0] lifetime_reg;
    ttt_pkg::cell_cmd_t         cmd;
    ttt_pkg::chain_stat_t       stat;
    ttt_pkg::action_t           in_action;
    ttt_pkg::status_t           out_status;
    logic [ttt_pkg::ID_W-1:0]   out_new_id;
    logic [ttt_pkg::TIME_W-1:0] out_accept_time;

    assign in_action = ttt_pkg::action_t'(s_tuser);
    assign m_tuser   = out_status;
    assign m_tdata   = {out_accept_time, out_new_id};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= ttt_pkg::LIFETIME_RESET;
        end
        else if (cfg_wr_en)
        begin
            lifetime_reg <= cfg_wr_data;
        end
    end

    ttt_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .in_action       (in_action),
        .in_tid          (s_tdata[15:0]),
        .in_now          (s_tdata[47:16]),
        .lifetime        (lifetime_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_status      (out_status),
        .out_new_id      (out_new_id),
        .out_accept_time (out_accept_time),
        .cmd             (cmd),
        .stat            (stat)
    );

    ttt_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for transaction_tracker_with_timeout: random and directed
// transactions on the stream ports, checked against an in-bench model of the table.
// Depends on ttt_pkg and the RTL of the tracker.
`timescale 1ns / 100ps
module testbench;
    import ttt_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TICKS = 40;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] offer;
        logic [TIME_W-1:0] astamp;
        logic              seen;
    } ledger_entry_t;

    typedef struct packed {
        action_t           act;
        logic [ID_W-1:0]   tid;
        logic [TIME_W-1:0] now;
    } request_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   new_id;
        logic [TIME_W-1:0] accept_time;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    ledger_entry_t     ledger[$];
    ledger_entry_t     plan_ledger[$];
    request_t          request_q[$];
    outcome_t          pending_outcomes[$];
    logic [TIME_W-1:0] life_limit = LIFETIME_RESET;
    logic [TIME_W-1:0] plan_life = LIFETIME_RESET;
    logic [TIME_W-1:0] plan_now = '0;
    request_t          next_req;
    outcome_t          want;
    bit                idle_on = 1'b1;
    int                send_gap = 0;
    int                hold_gap = 0;
    int                num_presented = 0;
    int                num_accepted = 0;
    int                fail_count = 0;
    int                cycle_count = 0;

    transaction_tracker_with_timeout i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic outcome_t track_step(ref ledger_entry_t led[$],
                                            input logic [TIME_W-1:0] life,
                                            input action_t act,
                                            input logic [ID_W-1:0] tid,
                                            input logic [TIME_W-1:0] now);
        outcome_t          res;
        ledger_entry_t     fresh;
        logic [TIME_W-1:0] age;
        int                i;
        int                hit;
        res = '0;
        res.status = STAT_DONE;
        hit = -1;
        if (tid != '0)
        begin
            for (i = led.size() - 1; i >= 0; i--)
            begin
                if (led[i].id == tid)
                    hit = i;
            end
        end
        case (act)
            ACT_CREATE:
            begin
                i = 0;
                while (i < led.size())
                begin
                    age = now - led[i].offer;
                    if (age > life)
                        led.delete(i);
                    else
                        i++;
                end
                if (led.size() >= TABLE_DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    if (led.size() == 0 || led[0].id == '1)
                        fresh.id = 1;
                    else
                        fresh.id = led[0].id + 1'b1;
                    fresh.offer = now;
                    fresh.astamp = '0;
                    fresh.seen = 1'b0;
                    led.push_front(fresh);
                    res.new_id = fresh.id;
                end
            end
            ACT_ACCEPT:
            begin
                if (hit < 0)
                    res.status = STAT_NOT_FOUND;
                else
                begin
                    led[hit].astamp = now;
                    led[hit].seen = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (hit < 0)
                    res.status = STAT_NOT_FOUND;
                else
                begin
                    if (led[hit].seen)
                        res.accept_time = led[hit].astamp;
                    else
                        res.status = STAT_NO_ACCEPT;
                    led.delete(hit);
                end
            end
            default:
                led.delete();
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        fail_count++;
        $display("mismatch in %s at cycle %0d: got %h, expected %h",
                 what, cycle_count, got, exp_val);
    endtask

    task automatic push_request(input action_t act, input logic [ID_W-1:0] tid,
                                input logic [TIME_W-1:0] now);
        request_t req;
        req.act = act;
        req.tid = tid;
        req.now = now;
        request_q.push_back(req);
        void'(track_step(plan_ledger, plan_life, act, tid, now));
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || num_accepted != num_presented ||
               pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_lifetime(input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        life_limit = value;
        plan_life = value;
    endtask

    task automatic random_phase(input logic [31:0] life, input int count,
                                input int create_pct, input bit gaps);
        action_t           act;
        logic [ID_W-1:0]   tid;
        logic [TIME_W-1:0] now;
        int                roll;
        wait_idle();
        set_lifetime(life);
        idle_on = gaps;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < create_pct)
                act = ACT_CREATE;
            else if (roll >= 97)
                act = ACT_CLEAR;
            else if (roll[0])
                act = ACT_ACCEPT;
            else
                act = ACT_REMOVE;
            if (plan_ledger.size() != 0 && $urandom_range(0, 9) < 8)
                tid = plan_ledger[$urandom_range(0, plan_ledger.size() - 1)].id;
            else if ($urandom_range(0, 3) == 0)
                tid = '0;
            else
                tid = $urandom;
            case ($urandom_range(0, 19))
                0: plan_now = plan_now + plan_life;
                1: plan_now = plan_now + plan_life + 1'b1;
                default:
                    if (plan_life < 8)
                        plan_now = plan_now + $urandom_range(0, 1);
                    else
                        plan_now = plan_now + $urandom_range(0, plan_life / 4);
            endcase
            now = ($urandom_range(0, 19) == 0) ? $urandom : plan_now;
            push_request(act, tid, now);
        end
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && num_accepted != num_presented))
        begin
            if (send_gap != 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (request_q.size() != 0)
            begin
                next_req = request_q.pop_front();
                s_tuser <= next_req.act;
                s_tdata <= {next_req.now, next_req.tid};
                s_tvalid <= 1'b1;
                num_presented <= num_presented + 1;
                send_gap <= idle_on ? pick_gap() : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_gap != 0)
        begin
            m_tready <= 1'b0;
            hold_gap <= hold_gap - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                hold_gap <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("unexpected transaction", {30'd0, m_tuser}, '0);
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", {30'd0, m_tuser}, {30'd0, want.status});
                    if (m_tdata[15:0] != want.new_id)
                        report_mismatch("new_id", {16'd0, m_tdata[15:0]},
                                        {16'd0, want.new_id});
                    if (m_tdata[47:16] != want.accept_time)
                        report_mismatch("accept_time", m_tdata[47:16], want.accept_time);
                end
            end
            if (s_tvalid && s_tready)
            begin
                pending_outcomes.push_back(track_step(ledger, life_limit,
                                                      action_t'(s_tuser),
                                                      s_tdata[15:0], s_tdata[47:16]));
                num_accepted = num_accepted + 1;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_request(ACT_ACCEPT, 16'd0, 32'd5);
        push_request(ACT_REMOVE, 16'hFFFF, 32'd6);
        push_request(ACT_CLEAR, 16'd0, 32'd7);
        push_request(ACT_CREATE, 16'hFFFF, 32'd100);
        push_request(ACT_CREATE, 16'd0, 32'd110);
        push_request(ACT_ACCEPT, 16'd0, 32'd120);
        push_request(ACT_ACCEPT, 16'd1, 32'd130);
        push_request(ACT_ACCEPT, 16'd1, 32'hFFFF_FFFF);
        push_request(ACT_REMOVE, 16'd1, 32'd140);
        push_request(ACT_REMOVE, 16'd2, 32'd150);
        push_request(ACT_REMOVE, 16'd2, 32'd160);
        push_request(ACT_CREATE, 16'd0, 32'd1000);
        push_request(ACT_CREATE, 16'd0, 32'd1001);
        push_request(ACT_CREATE, 16'd0, 32'd1001000);
        push_request(ACT_CREATE, 16'd0, 32'd1001001);
        push_request(ACT_CREATE, 16'd0, 32'hFFFF_FFFF);
        push_request(ACT_CREATE, 16'd0, 32'd5);
        push_request(ACT_ACCEPT, 16'd2, 32'd0);
        push_request(ACT_REMOVE, 16'd2, 32'd9);
        push_request(ACT_CLEAR, 16'hFFFF, 32'd10);
        push_request(ACT_REMOVE, 16'd1, 32'd11);

        random_phase(32'd1000, 200, 45, 1'b1);
        random_phase(32'hFFFF_FFFF, 200, 80, 1'b1);
        random_phase(32'd0, 150, 50, 1'b1);
        random_phase(32'd1, 150, 50, 1'b0);
        random_phase(32'd40, 200, 45, 1'b1);
        random_phase($urandom, 150, 45, 1'b1);
        random_phase(32'd1000000, 200, 60, 1'b1);
        // Start this phase just short of the wrap point of the time counter.
        plan_now = 32'hFFFF_FF00;
        random_phase(32'd300, 180, 40, 1'b1);
        wait_idle();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/ttt_pkg.sv
rtl/ttt_cell.sv
rtl/ttt_chain.sv
rtl/ttt_ctrl.sv
rtl/transaction_tracker_with_timeout.sv
tb/testbench.sv
